>>> rtl/sxe_pkg.sv
// ----------------------------------------------------------------------------
// sxe_pkg
// Shared types and opcodes for the SIC/XE execute unit.
// ----------------------------------------------------------------------------
package sxe_pkg;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [23:0] operand;
    logic [2:0]  first_reg;
    logic [2:0]  second_reg;
    logic [23:0] next_pc;
  } sxe_in_t;

  typedef struct packed {
    logic        mem_write;
    logic [23:0] mem_addr;
    logic [23:0] mem_data;
    logic [1:0]  mem_bytes;
    logic        branch_taken;
    logic [23:0] new_pc;
    logic [1:0]  cond_code;
    logic [1:0]  status;
  } sxe_out_t;

  // Operation classes decided by the front part
  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP,
    OP_ADDR, OP_SUBR, OP_MULR, OP_DIVR, OP_CMPR, OP_RMO, OP_CLEAR,
    OP_LOAD, OP_LDCH, OP_STORE, OP_STSW, OP_STCH,
    OP_JEQ, OP_JGT, OP_JLT, OP_J, OP_JSUB, OP_RSUB, OP_BAD
  } sxe_op_e;

  // Classified item passed from front to back
  typedef struct packed {
    sxe_op_e     op;
    logic [2:0]  reg_a;    // selector read (first), or cleared by CLEAR
    logic [2:0]  reg_b;    // selector read/written (second, or load target)
    logic [23:0] operand;
    logic [23:0] next_pc;
  } sxe_uop_t;

  localparam logic [7:0] OPC_ADD = 8'h18, OPC_SUB = 8'h1c, OPC_MUL = 8'h20;
  localparam logic [7:0] OPC_DIV = 8'h24, OPC_COMP = 8'h28;
  localparam logic [7:0] OPC_ADDR = 8'h90, OPC_SUBR = 8'h94, OPC_MULR = 8'h98;
  localparam logic [7:0] OPC_DIVR = 8'h9c, OPC_COMPR = 8'ha0, OPC_RMO = 8'hac;
  localparam logic [7:0] OPC_CLEAR = 8'hb4;
  localparam logic [7:0] OPC_LDA = 8'h00, OPC_LDX = 8'h04, OPC_LDL = 8'h08;
  localparam logic [7:0] OPC_LDB = 8'h68, OPC_LDS = 8'h6c, OPC_LDT = 8'h74;
  localparam logic [7:0] OPC_LDCH = 8'h50;
  localparam logic [7:0] OPC_STA = 8'h0c, OPC_STX = 8'h10, OPC_STL = 8'h14;
  localparam logic [7:0] OPC_STCH = 8'h54, OPC_STB = 8'h78, OPC_STS = 8'h7c;
  localparam logic [7:0] OPC_STT = 8'h84, OPC_STSW = 8'he8;
  localparam logic [7:0] OPC_JEQ = 8'h30, OPC_JGT = 8'h34, OPC_JLT = 8'h38;
  localparam logic [7:0] OPC_J = 8'h3c, OPC_JSUB = 8'h48, OPC_RSUB = 8'h4c;

  localparam logic [2:0] REG_A = 3'd0, REG_X = 3'd1, REG_L = 3'd2;
  localparam logic [2:0] REG_B = 3'd3, REG_S = 3'd4, REG_T = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0, ST_UNSUP = 2'd1, ST_DIV0 = 2'd2;
  localparam logic [1:0] CC_EQ = 2'd0, CC_GT = 2'd1, CC_LT = 2'd2;

endpackage

>>> rtl/sxe_front.sv
// ----------------------------------------------------------------------------
// sxe_front
// Decodes the opcode byte into an operation class and register selectors.
// ----------------------------------------------------------------------------
module sxe_front (
  input  sxe_pkg::sxe_in_t  item_i,
  output sxe_pkg::sxe_uop_t uop_o
);
  import sxe_pkg::*;

  always_comb begin
    uop_o.op      = OP_BAD;
    uop_o.reg_a   = item_i.first_reg;
    uop_o.reg_b   = item_i.second_reg;
    uop_o.operand = item_i.operand;
    uop_o.next_pc = item_i.next_pc;
    unique case (item_i.cmd)
      OPC_ADD:   uop_o.op = OP_ADD;
      OPC_SUB:   uop_o.op = OP_SUB;
      OPC_MUL:   uop_o.op = OP_MUL;
      OPC_DIV:   uop_o.op = OP_DIV;
      OPC_COMP:  uop_o.op = OP_CMP;
      OPC_ADDR:  uop_o.op = OP_ADDR;
      OPC_SUBR:  uop_o.op = OP_SUBR;
      OPC_MULR:  uop_o.op = OP_MULR;
      OPC_DIVR:  uop_o.op = OP_DIVR;
      OPC_COMPR: uop_o.op = OP_CMPR;
      OPC_RMO:   uop_o.op = OP_RMO;
      OPC_CLEAR: uop_o.op = OP_CLEAR;
      OPC_LDA:   begin uop_o.op = OP_LOAD; uop_o.reg_b = REG_A; end
      OPC_LDX:   begin uop_o.op = OP_LOAD; uop_o.reg_b = REG_X; end
      OPC_LDL:   begin uop_o.op = OP_LOAD; uop_o.reg_b = REG_L; end
      OPC_LDB:   begin uop_o.op = OP_LOAD; uop_o.reg_b = REG_B; end
      OPC_LDS:   begin uop_o.op = OP_LOAD; uop_o.reg_b = REG_S; end
      OPC_LDT:   begin uop_o.op = OP_LOAD; uop_o.reg_b = REG_T; end
      OPC_LDCH:  uop_o.op = OP_LDCH;
      OPC_STA:   begin uop_o.op = OP_STORE; uop_o.reg_a = REG_A; end
      OPC_STX:   begin uop_o.op = OP_STORE; uop_o.reg_a = REG_X; end
      OPC_STL:   begin uop_o.op = OP_STORE; uop_o.reg_a = REG_L; end
      OPC_STB:   begin uop_o.op = OP_STORE; uop_o.reg_a = REG_B; end
      OPC_STS:   begin uop_o.op = OP_STORE; uop_o.reg_a = REG_S; end
      OPC_STT:   begin uop_o.op = OP_STORE; uop_o.reg_a = REG_T; end
      OPC_STSW:  uop_o.op = OP_STSW;
      OPC_STCH:  uop_o.op = OP_STCH;
      OPC_JEQ:   uop_o.op = OP_JEQ;
      OPC_JGT:   uop_o.op = OP_JGT;
      OPC_JLT:   uop_o.op = OP_JLT;
      OPC_J:     uop_o.op = OP_J;
      OPC_JSUB:  uop_o.op = OP_JSUB;
      OPC_RSUB:  uop_o.op = OP_RSUB;
      default:   uop_o.op = OP_BAD;
    endcase
  end

endmodule

>>> rtl/sxe_queue.sv
// ----------------------------------------------------------------------------
// sxe_queue
// Two-entry queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module sxe_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  sxe_pkg::sxe_uop_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              empty_o,
  output sxe_pkg::sxe_uop_t rdata_o
);
  import sxe_pkg::*;

  sxe_uop_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wptr_q] <= wdata_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i && !full_o) wptr_q <= ~wptr_q;
      if (rd_i && !empty_o) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(wr_i && !full_o) - 2'(rd_i && !empty_o);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wptr_q != rptr_q))
    else $error("pointers disagree with count");
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !(rd_i && !empty_o) |=> full_o)
    else $error("full queue lost an entry");

endmodule

>>> rtl/sxe_divider.sv
// ----------------------------------------------------------------------------
// sxe_divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module sxe_divider #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, busy_q;
  logic [W:0]    trial;
  logic [W-1:0]  shrem;

  assign shrem  = {rem_q[W-2:0], quo_q[W-1]};
  assign trial  = {1'b0, shrem} - {1'b0, den_q};
  assign quot_o = neg_q ? (~quo_q + W'(1)) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitudes in, one shift-subtract step per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[W-1] ? (~num_i + W'(1)) : num_i;
      den_q <= den_i[W-1] ? (~den_i + W'(1)) : den_i;
      neg_q <= num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shrem;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/sxe_back.sv
// ----------------------------------------------------------------------------
// sxe_back
// Executes classified items against the register file and status word.
// ----------------------------------------------------------------------------
module sxe_back #(
  parameter int W = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  sxe_pkg::sxe_uop_t uop_i,
  output logic              q_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output sxe_pkg::sxe_out_t res_o
);
  import sxe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;

  state_e      state_q;
  logic [W-1:0] rf_q [7];
  logic [1:0]  cc_q;       // status bits 6:5 as condition
  sxe_uop_t    cur_q;
  logic [W-1:0] prod_q;
  logic        div_start, div_done;
  logic [W-1:0] div_quot;
  sxe_out_t    res_q;
  logic        res_v_q;
  sxe_out_t    res_d;
  logic [1:0]  cc_d;

  logic [W-1:0] ra, rb, val, npcw, lhs, rhs, srcnum, srcden;
  logic         is_mul, is_div;

  function automatic logic [W-1:0] ext24(logic [23:0] v);
    logic [W+23:0] t;
    t = {{W{v[23]}}, v};
    return t[W-1:0];
  endfunction

  function automatic logic [23:0] lo24(logic [W-1:0] v);
    logic [W+23:0] t;
    t = {24'd0, v};
    return t[23:0];
  endfunction

  assign ra   = (uop_i.reg_a == 3'd7) ? '0 : rf_q[uop_i.reg_a];
  assign rb   = (uop_i.reg_b == 3'd7) ? '0 : rf_q[uop_i.reg_b];
  assign val  = ext24(uop_i.operand);
  assign npcw = ext24(uop_i.next_pc);
  assign is_mul = uop_i.op == OP_MUL || uop_i.op == OP_MULR;
  assign is_div = uop_i.op == OP_DIV || uop_i.op == OP_DIVR;
  // operand pair for mul/div
  assign lhs    = (uop_i.op == OP_MUL) ? rf_q[REG_A] : ra;
  assign rhs    = (uop_i.op == OP_MUL) ? val : rb;
  assign srcnum = (uop_i.op == OP_DIV) ? rf_q[REG_A] : rb;
  assign srcden = (uop_i.op == OP_DIV) ? val : ra;

  assign empty_o = !res_v_q;
  assign res_o   = res_q;
  assign q_rd_o  = state_q == S_IDLE && !q_empty_i && !res_v_q;
  assign div_start = q_rd_o && is_div && srcden != '0;

  sxe_divider #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(srcnum), .den_i(srcden),
    .done_o(div_done), .quot_o(div_quot)
  );

  function automatic logic [1:0] cmpf(logic [W-1:0] a, logic [W-1:0] b);
    if ($signed(a) > $signed(b)) return CC_GT;
    if ($signed(a) < $signed(b)) return CC_LT;
    return CC_EQ;
  endfunction

  // condition and result fields for the item at the queue head
  always_comb begin
    cc_d = cc_q;
    unique case (uop_i.op)
      OP_CMP:  cc_d = cmpf(rf_q[REG_A], val);
      OP_CMPR: cc_d = cmpf(ra, rb);
      default: ;
    endcase
    res_d = '0;
    res_d.cond_code = cc_d;
    unique case (uop_i.op)
      OP_DIV, OP_DIVR: if (srcden == '0) res_d.status = ST_DIV0;
      OP_STORE: begin
        res_d.mem_write = 1'b1;
        res_d.mem_addr  = uop_i.operand;
        res_d.mem_data  = lo24(ra);
        res_d.mem_bytes = 2'd3;
      end
      OP_STSW: begin
        res_d.mem_write = 1'b1;
        res_d.mem_addr  = uop_i.operand;
        res_d.mem_data  = {17'd0, cc_q, 5'd0};
        res_d.mem_bytes = 2'd3;
      end
      OP_STCH: begin
        res_d.mem_write = 1'b1;
        res_d.mem_addr  = uop_i.operand;
        res_d.mem_data  = {16'd0, rf_q[REG_A][7:0]};
        res_d.mem_bytes = 2'd1;
      end
      OP_JEQ: if (cc_q == CC_EQ) begin
        res_d.branch_taken = 1'b1; res_d.new_pc = uop_i.operand;
      end
      OP_JGT: if (cc_q == CC_GT) begin
        res_d.branch_taken = 1'b1; res_d.new_pc = uop_i.operand;
      end
      OP_JLT: if (cc_q == CC_LT) begin
        res_d.branch_taken = 1'b1; res_d.new_pc = uop_i.operand;
      end
      OP_J, OP_JSUB: begin
        res_d.branch_taken = 1'b1; res_d.new_pc = uop_i.operand;
      end
      OP_RSUB: begin
        res_d.branch_taken = 1'b1; res_d.new_pc = lo24(rf_q[REG_L]);
      end
      OP_BAD:  res_d.status = ST_UNSUP;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_v_q <= 1'b0;
      cc_q    <= CC_EQ;
      cur_q   <= '0;
      prod_q  <= '0;
      res_q   <= '0;
      for (int i = 0; i < 7; i++) rf_q[i] <= '0;
    end else begin
      if (pop_i && res_v_q) res_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_rd_o) begin
          cur_q  <= uop_i;
          prod_q <= lhs * rhs;
          res_q  <= res_d;
          cc_q   <= cc_d;
          if (is_mul) state_q <= S_MUL;
          else if (is_div) begin
            if (srcden == '0) res_v_q <= 1'b1;
            else state_q <= S_DIV;
          end else begin
            res_v_q <= 1'b1;
            unique case (uop_i.op)
              OP_ADD:  rf_q[REG_A] <= rf_q[REG_A] + val;
              OP_SUB:  rf_q[REG_A] <= rf_q[REG_A] - val;
              OP_ADDR: if (uop_i.reg_b != 3'd7) rf_q[uop_i.reg_b] <= ra + rb;
              OP_SUBR: if (uop_i.reg_b != 3'd7) rf_q[uop_i.reg_b] <= rb - ra;
              OP_RMO:  if (uop_i.reg_b != 3'd7) rf_q[uop_i.reg_b] <= ra;
              OP_CLEAR: if (uop_i.reg_a != 3'd7) rf_q[uop_i.reg_a] <= '0;
              OP_LOAD: rf_q[uop_i.reg_b] <= val;
              OP_LDCH: rf_q[REG_A][7:0] <= uop_i.operand[7:0];
              OP_JSUB: rf_q[REG_L] <= npcw;
              default: ;
            endcase
          end
        end
        S_MUL: begin
          // registered product written back in the cycle after it is formed
          if (cur_q.op == OP_MUL) rf_q[REG_A] <= prod_q;
          else if (cur_q.reg_b != 3'd7) rf_q[cur_q.reg_b] <= prod_q;
          res_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_DIV: if (div_done) begin
          if (cur_q.op == OP_DIV) rf_q[REG_A] <= div_quot;
          else if (cur_q.reg_b != 3'd7) rf_q[cur_q.reg_b] <= div_quot;
          res_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !res_v_q)
    else $error("result valid while back end busy");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> !q_rd_o)
    else $error("took item with result pending");
  a_mul_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_IDLE))
    else $error("multiply writeback stuck");
  a_cc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni) cc_q != 2'd3)
    else $error("condition both greater and less");

endmodule

>>> rtl/sxe_execute_top_unused.sv
// ----------------------------------------------------------------------------
// sxe_trace_check
// Port-side checker for the result interface.
// ----------------------------------------------------------------------------
module sxe_trace_check (
  input logic clk_i,
  input logic rst_ni,
  input logic empty_i,
  input logic pop_i,
  input logic [1:0] status_i,
  input logic mem_write_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> !empty_i)
    else $error("result withdrawn before transfer");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && status_i != 2'd0) |-> !mem_write_i)
    else $error("store flagged on failed instruction");
  a_st_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> status_i != 2'd3)
    else $error("bad status code");
endmodule

>>> rtl/sic_xe_execute_unit.sv
// ----------------------------------------------------------------------------
// sic_xe_execute_unit
// SIC/XE execute unit: decode front, two-entry queue, execute back end.
// ----------------------------------------------------------------------------
// Channel  Direction  Transfer when        Payload
// input    in         push_i && !full_o    item_i  (sxe_in_t)
// result   out        pop_i && !empty_o    result_o (sxe_out_t)
//
// Most instructions pass through the queue and the back end, with the result
// registered. Mul adds the S_MUL state for the registered product. Div by a
// nonzero divisor waits in S_DIV for the one-bit-per-cycle divider.
// Reset clears registers, status word, queue and result register at once.
// A waiting result stalls the back end; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module sic_xe_execute_unit #(
  parameter int WORD_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  sxe_pkg::sxe_in_t  item_i,
  input  logic              pop_i,
  output logic              empty_o,
  output sxe_pkg::sxe_out_t result_o
);
  import sxe_pkg::*;

  sxe_uop_t uop_in, uop_out;
  logic     q_empty, q_rd;

  sxe_front u_front (.item_i(item_i), .uop_o(uop_in));

  sxe_queue u_queue (
    .clk_i, .rst_ni, .wr_i(push_i), .wdata_i(uop_in), .full_o(full_o),
    .rd_i(q_rd), .empty_o(q_empty), .rdata_o(uop_out)
  );

  sxe_back #(.W(WORD_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .uop_i(uop_out), .q_rd_o(q_rd),
    .empty_o(empty_o), .pop_i(pop_i), .res_o(result_o)
  );

  sxe_trace_check u_chk (
    .clk_i, .rst_ni, .empty_i(empty_o), .pop_i(pop_i),
    .status_i(result_o.status), .mem_write_i(result_o.mem_write)
  );

endmodule

>>> verif/sic_xe_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// sic_xe_execute_unit_tb
// Self-checking bench for the SIC/XE execute unit. Instructions are pushed
// through the input queue port while a predictor tracks the register file and
// status word; every popped result is compared field by field with the oldest
// predicted result. Random idling on both ports plus a long pop hold-off.
// ----------------------------------------------------------------------------
module sic_xe_execute_unit_tb;
  import sxe_pkg::*;

  localparam int WW = 24;
  localparam logic [WW-1:0] WMASK = '1;

  // Predictor of the execute unit plus the queue of predicted results
  class exec_scoreboard;
    logic [WW-1:0] regs [7];
    logic [23:0]   sw;
    sxe_out_t      pending [$];
    int            errors;

    function new();
      for (int i = 0; i < 7; i++) regs[i] = '0;
      sw = '0;
      errors = 0;
    endfunction

    function logic [WW-1:0] rd(logic [2:0] r);
      return (r < 3'd7) ? regs[r] : '0;
    endfunction

    function void wr(logic [2:0] r, logic [WW-1:0] v);
      if (r < 3'd7) regs[r] = v;
    endfunction

    function void compare(logic [WW-1:0] a, logic [WW-1:0] b);
      sw &= 24'h9f;
      if ($signed(a) > $signed(b)) sw |= 24'h20;
      if ($signed(a) < $signed(b)) sw |= 24'h40;
    endfunction

    // Signed quotient truncated toward zero; returns 0 on zero divisor
    function bit divide(logic [WW-1:0] n, logic [WW-1:0] d, output logic [WW-1:0] q);
      longint sn, sd;
      sn = $signed(n);
      sd = $signed(d);
      q = '0;
      if (sd == 0) return 0;
      q = WW'(sn / sd);
      return 1;
    endfunction

    // Execute one accepted instruction and queue the expected result
    function void note_item(sxe_in_t it);
      logic [WW-1:0] val, q;
      sxe_out_t o;
      bit br;
      int sreg;
      val = WW'($signed(it.operand));
      o = '0;
      br = 0;
      sreg = -1;
      case (it.cmd)
        OPC_ADD:   regs[0] = regs[0] + val;
        OPC_SUB:   regs[0] = regs[0] - val;
        OPC_MUL:   regs[0] = regs[0] * val;
        OPC_DIV:   if (divide(regs[0], val, q)) regs[0] = q; else o.status = ST_DIV0;
        OPC_COMP:  compare(regs[0], val);
        OPC_ADDR:  wr(it.second_reg, rd(it.first_reg) + rd(it.second_reg));
        OPC_SUBR:  wr(it.second_reg, rd(it.second_reg) - rd(it.first_reg));
        OPC_MULR:  wr(it.second_reg, rd(it.first_reg) * rd(it.second_reg));
        OPC_DIVR:  if (divide(rd(it.second_reg), rd(it.first_reg), q)) begin
          wr(it.second_reg, q);
        end else begin
          o.status = ST_DIV0;
        end
        OPC_COMPR: compare(rd(it.first_reg), rd(it.second_reg));
        OPC_RMO:   wr(it.second_reg, rd(it.first_reg));
        OPC_CLEAR: wr(it.first_reg, '0);
        OPC_LDA:   regs[REG_A] = val;
        OPC_LDX:   regs[REG_X] = val;
        OPC_LDL:   regs[REG_L] = val;
        OPC_LDB:   regs[REG_B] = val;
        OPC_LDS:   regs[REG_S] = val;
        OPC_LDT:   regs[REG_T] = val;
        OPC_LDCH:  regs[0][7:0] = it.operand[7:0];
        OPC_STA:   sreg = REG_A;
        OPC_STX:   sreg = REG_X;
        OPC_STL:   sreg = REG_L;
        OPC_STB:   sreg = REG_B;
        OPC_STS:   sreg = REG_S;
        OPC_STT:   sreg = REG_T;
        OPC_STSW: begin
          o.mem_write = 1'b1; o.mem_data = sw; o.mem_bytes = 2'd3;
        end
        OPC_STCH: begin
          o.mem_write = 1'b1; o.mem_data = {16'h0, regs[0][7:0]}; o.mem_bytes = 2'd1;
        end
        OPC_JEQ:   br = (sw[6:5] == 2'b00);
        OPC_JGT:   br = (sw[6:5] == 2'b01);
        OPC_JLT:   br = (sw[6:5] == 2'b10);
        OPC_J:     br = 1;
        OPC_JSUB: begin
          regs[REG_L] = WW'($signed(it.next_pc)); br = 1;
        end
        OPC_RSUB:  br = 1;
        default:   o.status = ST_UNSUP;
      endcase
      if (sreg >= 0) begin
        o.mem_write = 1'b1; o.mem_data = regs[sreg][23:0]; o.mem_bytes = 2'd3;
      end
      if (o.mem_write) o.mem_addr = it.operand;
      if (br) begin
        o.branch_taken = 1'b1;
        o.new_pc = (it.cmd == OPC_RSUB) ? regs[REG_L][23:0] : it.operand;
      end
      o.cond_code = sw[6:5];
      pending.push_back(o);
    endfunction

    function void check_result(sxe_out_t got);
      sxe_out_t e;
      if (pending.size() == 0) begin
        $error("result with no instruction outstanding: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.mem_write !== e.mem_write) begin
        $error("mem_write exp %h got %h", e.mem_write, got.mem_write); errors++;
      end
      if (got.mem_addr !== e.mem_addr) begin
        $error("mem_addr exp %h got %h", e.mem_addr, got.mem_addr); errors++;
      end
      if (got.mem_data !== e.mem_data) begin
        $error("mem_data exp %h got %h", e.mem_data, got.mem_data); errors++;
      end
      if (got.mem_bytes !== e.mem_bytes) begin
        $error("mem_bytes exp %h got %h", e.mem_bytes, got.mem_bytes); errors++;
      end
      if (got.branch_taken !== e.branch_taken) begin
        $error("branch_taken exp %h got %h", e.branch_taken, got.branch_taken); errors++;
      end
      if (got.new_pc !== e.new_pc) begin
        $error("new_pc exp %h got %h", e.new_pc, got.new_pc); errors++;
      end
      if (got.cond_code !== e.cond_code) begin
        $error("cond_code exp %h got %h", e.cond_code, got.cond_code); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %h got %h", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push_i = 1'b0;
  logic     pop_i = 1'b0;
  logic     full_o, empty_o;
  sxe_in_t  item_i = '0;
  sxe_out_t result_o;

  exec_scoreboard sb = new();
  int  push_idle_pct = 12;
  int  pop_idle_pct = 67;
  bit  pop_hold = 0;
  bit  producing_done = 0;

  sic_xe_execute_unit #(.WORD_WIDTH(WW)) dut (
    .clk_i, .rst_ni, .push_i, .full_o, .item_i, .pop_i, .empty_o, .result_o
  );

  always #4 clk_i = ~clk_i;

  // Limit on total run time
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Valid opcodes, used to bias random stimulus toward real instructions
  logic [7:0] opcodes [] = '{
    OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_COMP, OPC_ADDR, OPC_SUBR, OPC_MULR,
    OPC_DIVR, OPC_COMPR, OPC_RMO, OPC_CLEAR, OPC_LDA, OPC_LDX, OPC_LDL, OPC_LDB,
    OPC_LDS, OPC_LDT, OPC_LDCH, OPC_STA, OPC_STX, OPC_STL, OPC_STCH, OPC_STB,
    OPC_STS, OPC_STT, OPC_STSW, OPC_JEQ, OPC_JGT, OPC_JLT, OPC_J, OPC_JSUB,
    OPC_RSUB
  };

  // Push one instruction, with optional random idle cycles ahead of it;
  // push stays high after the transfer until the next idle or the next item
  task automatic send(sxe_in_t it);
    while ($urandom_range(99) < push_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic send_op(logic [7:0] c, logic [23:0] opd, logic [2:0] r1 = 0,
                         logic [2:0] r2 = 0, logic [23:0] npc = 0);
    sxe_in_t it;
    it.cmd = c; it.operand = opd; it.first_reg = r1; it.second_reg = r2;
    it.next_pc = npc;
    send(it);
  endtask

  // Small operands make interesting compares and quotients more likely
  function automatic logic [23:0] rand_operand();
    case ($urandom_range(3))
      0: return 24'($urandom_range(15));
      1: return 24'(-$urandom_range(1, 15));
      2: return ($urandom_range(1)) ? 24'h800000 : 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // Result side: pop with random stalls, check each transfer
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_result(result_o);
      pop_i <= !pop_hold && ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Main stimulus
  initial begin
    sxe_in_t it;
    int hold;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, most classes, divide by zero, wrap, selector seven
    send_op(OPC_LDA, 24'h800000);
    send_op(OPC_DIV, 24'hffffff);
    send_op(OPC_STA, 24'hffffff);
    send_op(OPC_DIV, 24'h0);
    send_op(OPC_LDX, 24'h7fffff);
    send_op(OPC_ADDR, 0, REG_X, REG_A);
    send_op(OPC_MULR, 0, REG_X, 3'd7);
    send_op(OPC_DIVR, 0, 3'd7, REG_A);
    send_op(OPC_COMPR, 0, REG_A, REG_X);
    send_op(OPC_JLT, 24'h123456);
    send_op(OPC_JGT, 24'h123456);
    send_op(OPC_COMP, 24'hffffff);
    send_op(OPC_JGT, 24'habcdef);
    send_op(OPC_STSW, 24'h000100);
    send_op(OPC_LDCH, 24'hffffab);
    send_op(OPC_STCH, 24'h0);
    send_op(OPC_JSUB, 24'h000200, 0, 0, 24'hfedcba);
    send_op(OPC_RSUB, 24'h0);
    send_op(OPC_CLEAR, 0, REG_A);
    send_op(OPC_COMPR, 0, REG_A, 3'd7);
    send_op(OPC_JEQ, 24'h000300);
    send_op(8'hd8, 24'h0);
    send_op(8'hdc, 24'hffffff, 3'd7, 3'd7, 24'hffffff);
    send_op(OPC_RMO, 0, 3'd7, REG_B);

    // Long receiver hold-off so the queue fills and push stalls
    pop_hold = 1;
    fork
      begin
        hold = 0;
        while (hold < 60) begin
          @(posedge clk_i);
          hold++;
        end
        pop_hold = 0;
      end
      for (int k = 0; k < 8; k++) send_op(opcodes[$urandom_range(opcodes.size()-1)],
                                          rand_operand(), 3'($urandom), 3'($urandom),
                                          24'($urandom));
    join

    // Random phases: sender idle light, then heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      push_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 67 : 0;
      pop_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 12 : 0;
      for (int n = 0; n < 300; n++) begin
        it.cmd = ($urandom_range(19) == 0) ? 8'($urandom)
                 : opcodes[$urandom_range(opcodes.size()-1)];
        it.operand = rand_operand();
        it.first_reg = 3'($urandom);
        it.second_reg = 3'($urandom);
        it.next_pc = 24'($urandom);
        send(it);
      end
    end
    push_i <= 1'b0;

    // Drain
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
